[design/ps2mpd_pkg.sv]
// Shared types and constants for the PS/2 mouse packet deframer with byte FIFO.
package ps2mpd_pkg;

    localparam int FifoBytesDefault = 1024;
    localparam int FillW            = 11;

    localparam logic [1:0] OP_RX    = 2'd0;
    localparam logic [1:0] OP_POP   = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [7:0] HDR_MASK  = 8'hc8;
    localparam logic [7:0] HDR_MATCH = 8'h08;
    localparam logic [7:0] MARKER    = 8'd27;

    typedef enum logic [1:0] {
        PH_HDR,
        PH_X,
        PH_Y
    } t_phase;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] rx_byte;
    } t_in_word;

    typedef struct packed {
        logic [7:0]       read_data;
        logic             read_valid;
        logic             packet_queued;
        logic             packet_dropped;
        logic [FillW-1:0] fill_level;
    } t_out_word;

    typedef struct packed {
        logic       done;
        logic [7:0] header;
        logic [7:0] x;
        logic [7:0] neg_y;
    } t_pkt;

    typedef struct packed {
        logic rd_hit;
        logic queued;
        logic dropped;
    } t_fifo_evt;

endpackage

[design/ps2mpd_parser.sv]
// Three-byte PS/2 mouse packet parser: header, X, then Y (negated).
module ps2mpd_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_byte_en,
    input  logic [7:0]         i_rx_byte,
    output ps2mpd_pkg::t_pkt   o_pkt
);

    ps2mpd_pkg::t_phase r_phase;
    ps2mpd_pkg::t_phase n_phase;
    logic [7:0]         r_header;
    logic [7:0]         n_header;
    logic [7:0]         r_x;
    logic [7:0]         n_x;
    logic               w_hdr_ok;

    assign w_hdr_ok = (i_rx_byte & ps2mpd_pkg::HDR_MASK) == ps2mpd_pkg::HDR_MATCH;

    always_comb begin
        n_phase = r_phase;
        if (i_byte_en) begin
            case (r_phase)
                ps2mpd_pkg::PH_X: n_phase = ps2mpd_pkg::PH_Y;
                ps2mpd_pkg::PH_Y: n_phase = ps2mpd_pkg::PH_HDR;
                default:          n_phase = w_hdr_ok ? ps2mpd_pkg::PH_X : ps2mpd_pkg::PH_HDR;
            endcase
        end
    end

    always_comb begin
        n_header     = r_header;
        n_x          = r_x;
        o_pkt.done   = 1'b0;
        o_pkt.header = r_header;
        o_pkt.x      = r_x;
        o_pkt.neg_y  = 8'(~i_rx_byte + 8'd1);
        if (i_byte_en) begin
            case (r_phase)
                ps2mpd_pkg::PH_X: n_x = i_rx_byte;
                ps2mpd_pkg::PH_Y: o_pkt.done = 1'b1;
                default: begin
                    if (w_hdr_ok) begin
                        n_header = i_rx_byte;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= ps2mpd_pkg::PH_HDR;
            r_header <= 8'd0;
            r_x      <= 8'd0;
        end else begin
            r_phase  <= n_phase;
            r_header <= n_header;
            r_x      <= n_x;
        end
    end

endmodule

[design/ps2mpd_fifo.sv]
// Byte FIFO stored one four-byte packet per memory word, with pop and clear.
module ps2mpd_fifo #(
    parameter int FIFO_BYTES = ps2mpd_pkg::FifoBytesDefault,
    parameter int CNT_W      = $clog2(FIFO_BYTES + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_go,
    input  logic [1:0]            i_opcode,
    input  ps2mpd_pkg::t_pkt      i_pkt,
    output ps2mpd_pkg::t_fifo_evt o_evt,
    output logic [CNT_W-1:0]      o_count_next,
    output logic [7:0]            o_rd_byte
);

    localparam int WordDepth = (FIFO_BYTES + 3) / 4;
    localparam int WordAw    = (WordDepth > 1) ? $clog2(WordDepth) : 1;

    localparam logic [CNT_W-1:0]  RoomMax  = CNT_W'(FIFO_BYTES - 4);
    localparam logic [WordAw-1:0] WordLast = WordAw'(WordDepth - 1);

    logic [31:0]       r_mem [WordDepth];
    logic [WordAw-1:0] r_wr_word;
    logic [WordAw-1:0] n_wr_word;
    logic [WordAw-1:0] r_rd_word;
    logic [WordAw-1:0] n_rd_word;
    logic [1:0]        r_rd_lane;
    logic [1:0]        n_rd_lane;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic [31:0]       r_rd_data;
    logic [1:0]        r_rd_sel;
    logic              w_wr;
    logic              w_is_pkt;

    assign w_is_pkt      = i_go && (i_opcode == ps2mpd_pkg::OP_RX) && i_pkt.done;
    assign w_wr          = w_is_pkt && (r_count <= RoomMax);
    assign o_evt.queued  = w_wr;
    assign o_evt.dropped = w_is_pkt && !(r_count <= RoomMax);
    assign o_evt.rd_hit  = i_go && (i_opcode == ps2mpd_pkg::OP_POP) && (r_count != '0);
    assign o_count_next  = n_count;
    assign o_rd_byte     = r_rd_data[{r_rd_sel, 3'b000} +: 8];

    always_comb begin
        n_wr_word = r_wr_word;
        n_rd_word = r_rd_word;
        n_rd_lane = r_rd_lane;
        n_count   = r_count;
        if (i_go) begin
            case (i_opcode)
                ps2mpd_pkg::OP_RX: begin
                    if (w_wr) begin
                        n_wr_word = (r_wr_word == WordLast) ? '0 : r_wr_word + WordAw'(1);
                        n_count   = r_count + CNT_W'(4);
                    end
                end
                ps2mpd_pkg::OP_POP: begin
                    if (o_evt.rd_hit) begin
                        n_rd_lane = r_rd_lane + 2'd1;
                        if (r_rd_lane == 2'd3) begin
                            n_rd_word = (r_rd_word == WordLast) ? '0 : r_rd_word + WordAw'(1);
                        end
                        n_count = r_count - CNT_W'(1);
                    end
                end
                ps2mpd_pkg::OP_CLEAR: begin
                    n_wr_word = '0;
                    n_rd_word = '0;
                    n_rd_lane = 2'd0;
                    n_count   = '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_word <= '0;
            r_rd_word <= '0;
            r_rd_lane <= 2'd0;
            r_count   <= '0;
        end else begin
            r_wr_word <= n_wr_word;
            r_rd_word <= n_rd_word;
            r_rd_lane <= n_rd_lane;
            r_count   <= n_count;
        end
    end

    // lane 0 holds the marker, lane 3 the negated Y
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_word] <= {i_pkt.neg_y, i_pkt.x, i_pkt.header, ps2mpd_pkg::MARKER};
        end
        if (o_evt.rd_hit) begin
            r_rd_data <= r_mem[r_rd_word];
            r_rd_sel  <= r_rd_lane;
        end
    end

endmodule

[design/ps2_mouse_packet_deframer_fifo_core.sv]
// Top level: PS/2 mouse packet deframer feeding a byte FIFO, with result pipeline.
// Each input word is a mouse byte, a pop or a clear and yields exactly one result
// word. One word is accepted every clock while input stall is low; each result passes
// through the registered read port of the FIFO memory and then the output register.
// Up to two results may be held while the output is
// stalled before input stall rises. A completed packet is stored as the four bytes
// marker 27, header, X and negated Y when at least four bytes of room remain.
module ps2_mouse_packet_deframer_fifo_core #(
    parameter int FIFO_BYTES = ps2mpd_pkg::FifoBytesDefault
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  ps2mpd_pkg::t_in_word  i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output ps2mpd_pkg::t_out_word o_out
);

    localparam int CntW  = $clog2(FIFO_BYTES + 1);
    localparam int FillW = ps2mpd_pkg::FillW;

    logic                         w_accept;
    logic                         w_out_free;
    logic                         w_s1_adv;
    ps2mpd_pkg::t_pkt             w_pkt;
    ps2mpd_pkg::t_fifo_evt        w_evt;
    logic [CntW-1:0]              w_count_next;
    logic [CntW+FillW-1:0]        w_fill_wide;
    logic [7:0]                   w_rd_byte;

    logic                         r_s1_valid;
    logic                         r_s1_rvalid;
    logic                         r_s1_queued;
    logic                         r_s1_dropped;
    logic [FillW-1:0]             r_s1_fill;
    logic                         r_out_valid;
    ps2mpd_pkg::t_out_word        r_out;

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_s1_adv    = r_s1_valid && w_out_free;
    assign o_in_stall  = r_s1_valid && !w_out_free;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_fill_wide = {{FillW{1'b0}}, w_count_next};
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    ps2mpd_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_byte_en (w_accept && (i_in.opcode == ps2mpd_pkg::OP_RX)),
        .i_rx_byte (i_in.rx_byte),
        .o_pkt     (w_pkt)
    );

    ps2mpd_fifo #(
        .FIFO_BYTES (FIFO_BYTES),
        .CNT_W      (CntW)
    ) u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_go         (w_accept),
        .i_opcode     (i_in.opcode),
        .i_pkt        (w_pkt),
        .o_evt        (w_evt),
        .o_count_next (w_count_next),
        .o_rd_byte    (w_rd_byte)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_rvalid  <= w_evt.rd_hit;
            r_s1_queued  <= w_evt.queued;
            r_s1_dropped <= w_evt.dropped;
            r_s1_fill    <= w_fill_wide[FillW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_out.read_data      <= r_s1_rvalid ? w_rd_byte : 8'd0;
            r_out.read_valid     <= r_s1_rvalid;
            r_out.packet_queued  <= r_s1_queued;
            r_out.packet_dropped <= r_s1_dropped;
            r_out.fill_level     <= r_s1_fill;
        end
    end

endmodule

[tb/sv/deframer_checker.sv]
// Checker for the PS/2 packet deframer: predicts every result word and compares it.
module deframer_checker #(
    parameter int FIFO_BYTES = ps2mpd_pkg::FifoBytesDefault
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  ps2mpd_pkg::t_in_word  i_in,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  ps2mpd_pkg::t_out_word i_out,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam int FillW = ps2mpd_pkg::FillW;

    ps2mpd_pkg::t_phase    phase;
    logic [7:0]            hdr_byte;
    logic [7:0]            x_byte;
    logic [7:0]            byte_store [FIFO_BYTES];
    int                    rd_ptr;
    int                    wr_ptr;
    int                    byte_count;
    int                    errors;
    ps2mpd_pkg::t_out_word pending_results [$];

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("ERROR @%0t: %s got 0x%0h, want 0x%0h", $time, what, got, want);
        errors++;
    endtask

    function automatic void put_byte(input logic [7:0] b);
        byte_store[wr_ptr] = b;
        wr_ptr = (wr_ptr + 1) % FIFO_BYTES;
        byte_count++;
    endfunction

    function automatic ps2mpd_pkg::t_out_word next_result(input ps2mpd_pkg::t_in_word w);
        ps2mpd_pkg::t_out_word r;
        r = '0;
        case (w.opcode)
            ps2mpd_pkg::OP_RX: begin
                case (phase)
                    ps2mpd_pkg::PH_X: begin
                        x_byte = w.rx_byte;
                        phase  = ps2mpd_pkg::PH_Y;
                    end
                    ps2mpd_pkg::PH_Y: begin
                        phase = ps2mpd_pkg::PH_HDR;
                        if (byte_count + 4 <= FIFO_BYTES) begin
                            put_byte(ps2mpd_pkg::MARKER);
                            put_byte(hdr_byte);
                            put_byte(x_byte);
                            put_byte(8'(8'd0 - w.rx_byte));
                            r.packet_queued = 1'b1;
                        end else begin
                            r.packet_dropped = 1'b1;
                        end
                    end
                    default: begin
                        phase = ps2mpd_pkg::PH_HDR;
                        if ((w.rx_byte & ps2mpd_pkg::HDR_MASK) == ps2mpd_pkg::HDR_MATCH) begin
                            hdr_byte = w.rx_byte;
                            phase    = ps2mpd_pkg::PH_X;
                        end
                    end
                endcase
            end
            ps2mpd_pkg::OP_POP: begin
                if (byte_count != 0) begin
                    r.read_data  = byte_store[rd_ptr];
                    r.read_valid = 1'b1;
                    rd_ptr       = (rd_ptr + 1) % FIFO_BYTES;
                    byte_count--;
                end
            end
            ps2mpd_pkg::OP_CLEAR: begin
                rd_ptr     = 0;
                wr_ptr     = 0;
                byte_count = 0;
            end
            default: begin
            end
        endcase
        r.fill_level = FillW'(byte_count);
        return r;
    endfunction

    always @(posedge i_clk) begin
        ps2mpd_pkg::t_out_word want;
        if (!i_rst_n) begin
            phase      = ps2mpd_pkg::PH_HDR;
            hdr_byte   = '0;
            x_byte     = '0;
            rd_ptr     = 0;
            wr_ptr     = 0;
            byte_count = 0;
            errors     = 0;
            pending_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected word, fill_level", i_out.fill_level, 0);
                end else begin
                    want = pending_results.pop_front();
                    if (i_out.read_data !== want.read_data) begin
                        report_mismatch("read_data", i_out.read_data, want.read_data);
                    end
                    if (i_out.read_valid !== want.read_valid) begin
                        report_mismatch("read_valid", i_out.read_valid, want.read_valid);
                    end
                    if (i_out.packet_queued !== want.packet_queued) begin
                        report_mismatch("packet_queued", i_out.packet_queued,
                                        want.packet_queued);
                    end
                    if (i_out.packet_dropped !== want.packet_dropped) begin
                        report_mismatch("packet_dropped", i_out.packet_dropped,
                                        want.packet_dropped);
                    end
                    if (i_out.fill_level !== want.fill_level) begin
                        report_mismatch("fill_level", i_out.fill_level, want.fill_level);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                pending_results.push_back(next_result(i_in));
            end
        end
        o_fail_count <= errors;
        o_pending    <= pending_results.size();
    end

endmodule

[tb/sv/testbench.sv]
// Testbench top: drives the deframer with mouse bytes, pops and clears, and gives the verdict.
module testbench;

    localparam logic [1:0] OP_NOP      = 2'd3;
    localparam int         END_WAIT    = 20;
    localparam int         CYCLE_LIMIT = 300000;
    localparam int         LONG_HOLD   = 300;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    ps2mpd_pkg::t_in_word  in_word;
    logic                  out_valid;
    logic                  out_stall;
    ps2mpd_pkg::t_out_word out_word;
    int                    fail_count;
    int                    pending;
    int                    cycles = 0;
    int                    words_sent = 0;
    logic                  in_burst;
    logic                  out_burst;
    logic                  hold_out;

    ps2_mouse_packet_deframer_fifo_core i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in       (in_word),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out      (out_word)
    );

    deframer_checker u_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in        (in_word),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out       (out_word),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send_word(input logic [1:0] op, input logic [7:0] b);
        int gap;
        gap = in_burst ? 0 : $urandom_range(0, 9);
        repeat (gap) begin
            @(negedge clk);
            in_valid = 1'b0;
        end
        @(negedge clk);
        in_valid        = 1'b1;
        in_word.opcode  = op;
        in_word.rx_byte = b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        words_sent++;
        if ($urandom_range(0, 39) == 0) begin
            in_burst = !in_burst;
        end
    endtask

    task automatic send_packet(input logic [7:0] hdr, input logic [7:0] x,
                               input logic [7:0] y);
        send_word(ps2mpd_pkg::OP_RX, hdr);
        send_word(ps2mpd_pkg::OP_RX, x);
        send_word(ps2mpd_pkg::OP_RX, y);
    endtask

    function automatic logic [7:0] rand_header();
        logic [7:0] b;
        b      = 8'($urandom);
        b[7:6] = 2'b00;
        b[3]   = 1'b1;
        return b;
    endfunction

    function automatic logic [1:0] rand_op();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
            return OP_NOP;
        end else if (pick < 8) begin
            return ps2mpd_pkg::OP_RX;
        end else if (pick < 17) begin
            return ps2mpd_pkg::OP_POP;
        end
        return ps2mpd_pkg::OP_CLEAR;
    endfunction

    task automatic wait_drained();
        @(negedge clk);
        in_valid = 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // mostly well-formed packets, with pops, clears, noise and cut-off packets mixed in
    task automatic run_mixed(input int n);
        int stop_at;
        int pick;
        stop_at = words_sent + n;
        while (words_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                send_packet(rand_header(), 8'($urandom), 8'($urandom));
            end else if (pick < 62) begin
                send_word(ps2mpd_pkg::OP_RX, rand_header());
                repeat ($urandom_range(1, 3)) send_word(rand_op(), 8'($urandom));
            end else if (pick < 82) begin
                repeat ($urandom_range(1, 6)) send_word(ps2mpd_pkg::OP_POP, 8'($urandom));
            end else if (pick < 85) begin
                send_word(ps2mpd_pkg::OP_CLEAR, 8'($urandom));
            end else if (pick < 87) begin
                send_word(OP_NOP, 8'($urandom));
            end else begin
                send_word(ps2mpd_pkg::OP_RX, 8'($urandom));
            end
        end
    endtask

    initial begin
        int gap;
        out_stall = 1'b0;
        out_burst = 1'b0;
        @(posedge rst_n);
        forever begin
            if (hold_out) begin
                hold_out = 1'b0;
                @(negedge clk);
                out_stall = 1'b1;
                repeat (LONG_HOLD - 1) @(negedge clk);
            end
            gap = out_burst ? 0 : $urandom_range(0, 9);
            repeat (gap) begin
                @(negedge clk);
                out_stall = 1'b1;
            end
            @(negedge clk);
            out_stall = 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            if ($urandom_range(0, 39) == 0) begin
                out_burst = !out_burst;
            end
        end
    end

    initial begin
        logic [7:0] junk [6];
        junk     = '{8'hff, 8'hc8, 8'h48, 8'h88, 8'h00, 8'hf7};
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_word  = '0;
        in_burst = 1'b0;
        hold_out = 1'b0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        send_word(ps2mpd_pkg::OP_POP, 8'h00);
        send_word(OP_NOP, 8'hff);
        foreach (junk[k]) begin
            send_word(ps2mpd_pkg::OP_RX, junk[k]);
        end
        send_packet(8'h08, 8'h00, 8'h00);
        send_packet(8'h3f, 8'hff, 8'h80);
        // parser keeps its place across clear, no-op and pop
        send_word(ps2mpd_pkg::OP_RX, 8'h18);
        send_word(ps2mpd_pkg::OP_CLEAR, 8'h5a);
        send_word(ps2mpd_pkg::OP_RX, 8'h7f);
        send_word(OP_NOP, 8'h00);
        send_word(ps2mpd_pkg::OP_POP, 8'ha5);
        send_word(ps2mpd_pkg::OP_RX, 8'h01);
        repeat (6) send_word(ps2mpd_pkg::OP_POP, 8'h00);
        wait_drained();

        run_mixed(60);
        wait_drained();

        // fill to capacity while the output is held off, then probe the room check
        send_word(ps2mpd_pkg::OP_CLEAR, 8'h00);
        hold_out = 1'b1;
        repeat (258) send_packet(rand_header(), 8'($urandom), 8'($urandom));
        repeat (10) send_word(ps2mpd_pkg::OP_POP, 8'($urandom));
        repeat (3) send_packet(rand_header(), 8'($urandom), 8'($urandom));
        repeat (2) send_word(ps2mpd_pkg::OP_POP, 8'($urandom));
        repeat (2) send_packet(rand_header(), 8'($urandom), 8'($urandom));
        send_word(ps2mpd_pkg::OP_CLEAR, 8'($urandom));
        wait_drained();

        run_mixed(40);
        wait_drained();
        repeat (END_WAIT) @(posedge clk);

        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
